FILE: design/tcw_pkg.sv
// ----------------------------------------------------------------------------
// tcw_pkg
// Shared codes and the command and status bundles between the console
// writer's controller and datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package tcw_pkg;

    // request codes
    localparam logic [1:0] REQ_PUT   = 2'd0;
    localparam logic [1:0] REQ_CLEAR = 2'd1;
    localparam logic [1:0] REQ_READ  = 2'd2;

    localparam logic [7:0] NEWLINE_CODE  = 8'd10;
    localparam logic [7:0] SPACE_CODE    = 8'd32;
    localparam logic [7:0] RESET_COLOR   = 8'd15;

    // controller to datapath
    typedef struct packed {
        logic accept;     // item taken this cycle
        logic sweep_wr;   // write one fill cell
        logic load_read;  // capture read data into the result register
    } t_ctl_cmd;

    // datapath to controller
    typedef struct packed {
        logic can_load;   // result register free this cycle
        logic is_read;    // offered item is a read
        logic is_clear;   // offered item is a clear
        logic scroll;     // offered item is a put that scrolls
        logic sweep_last; // fill writes its last cell this cycle
    } t_dp_status;

endpackage

`default_nettype wire

FILE: design/tcw_datapath.sv
// ----------------------------------------------------------------------------
// tcw_datapath
// Screen store, cursor, row offset, fill sweep and result register. The
// store is addressed through a rotating row offset, so a scroll only
// blanks one line.
// ----------------------------------------------------------------------------
`default_nettype none

module tcw_datapath #(
    parameter int COLUMNS   = 80,
    parameter int ROW_COUNT = 25
) (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  tcw_pkg::t_ctl_cmd    i_cmd,
    output tcw_pkg::t_dp_status  o_status,
    input  wire  [1:0]           i_req_type,
    input  wire  [7:0]           i_char_code,
    input  wire  [7:0]           i_color,
    input  wire  [10:0]          i_cell_index,
    output logic                 o_out_valid,
    input  wire                  i_out_stall,
    output logic [15:0]          o_cell_value,
    output logic [6:0]           o_cursor_column,
    output logic [4:0]           o_cursor_row,
    output logic                 o_did_scroll
);
    import tcw_pkg::*;

    localparam int CELL_COUNT = COLUMNS * ROW_COUNT;
    localparam int AW = $clog2(CELL_COUNT);
    localparam int CW = $clog2(COLUMNS);
    localparam int RW = $clog2(ROW_COUNT);
    localparam int IW = (AW > 11) ? AW + 1 : 12;

    logic [15:0]   r_mem [CELL_COUNT];

    logic [CW-1:0] r_col, n_col;
    logic [RW-1:0] r_row, n_row;
    logic [7:0]    r_color, n_color;
    logic [AW-1:0] r_base, n_base;
    logic [AW-1:0] r_line, n_line;

    logic [AW-1:0] r_sweep_addr;
    logic [AW-1:0] r_sweep_left;
    logic [15:0]   r_sweep_data;

    logic [15:0]   r_rd_data;
    logic          r_rd_oor;

    logic          r_out_valid;
    logic [15:0]   r_out_value;
    logic [6:0]    r_out_col;
    logic [4:0]    r_out_row;
    logic          r_out_scroll;

    logic          is_put, is_clear, is_read, is_nl, at_eol, at_last, scroll;
    logic [AW:0]   line_sum, base_sum, rd_sum;
    logic [AW-1:0] line_adv, base_adv, put_addr, rd_addr;
    logic [IW-1:0] idx_ext;
    logic          in_range;
    logic          mem_we;
    logic [AW-1:0] mem_wa;
    logic [15:0]   mem_wd;
    logic          can_load;

    assign is_put   = (i_req_type == REQ_PUT);
    assign is_clear = (i_req_type == REQ_CLEAR);
    assign is_read  = (i_req_type == REQ_READ);
    assign is_nl    = (i_char_code == NEWLINE_CODE);
    assign at_eol   = is_nl || (r_col == CW'(COLUMNS - 1));
    assign at_last  = (r_row == RW'(ROW_COUNT - 1));
    assign scroll   = is_put && at_eol && at_last;

    // line starts never pass the end of the store, so one compare wraps them
    assign line_sum = (AW+1)'(r_line) + (AW+1)'(COLUMNS);
    assign base_sum = (AW+1)'(r_base) + (AW+1)'(COLUMNS);
    assign line_adv = (line_sum == (AW+1)'(CELL_COUNT)) ? '0 : AW'(line_sum);
    assign base_adv = (base_sum == (AW+1)'(CELL_COUNT)) ? '0 : AW'(base_sum);
    assign put_addr = AW'((AW+1)'(r_line) + (AW+1)'(r_col));

    assign idx_ext  = IW'(i_cell_index);
    assign in_range = (idx_ext < IW'(CELL_COUNT));
    assign rd_sum   = (AW+1)'(AW'(idx_ext)) + (AW+1)'(r_base);
    assign rd_addr  = (rd_sum >= (AW+1)'(CELL_COUNT)) ?
                      AW'(rd_sum - (AW+1)'(CELL_COUNT)) : AW'(rd_sum);

    always_comb begin
        n_col   = r_col;
        n_row   = r_row;
        n_color = r_color;
        n_base  = r_base;
        n_line  = r_line;
        if (is_put) begin
            if (!at_eol) begin
                n_col = r_col + CW'(1);
            end else begin
                n_col = '0;
                if (at_last) begin
                    // old top line becomes the new bottom line
                    n_base = base_adv;
                    n_line = r_base;
                end else begin
                    n_row  = r_row + RW'(1);
                    n_line = line_adv;
                end
            end
        end else if (is_clear) begin
            n_col   = '0;
            n_row   = '0;
            n_base  = '0;
            n_line  = '0;
            n_color = i_color;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col   <= '0;
            r_row   <= '0;
            r_color <= RESET_COLOR;
            r_base  <= '0;
            r_line  <= '0;
        end else if (i_cmd.accept) begin
            r_col   <= n_col;
            r_row   <= n_row;
            r_color <= n_color;
            r_base  <= n_base;
            r_line  <= n_line;
        end
    end

    // fill sweep: zero after reset, colored spaces for clear and scroll
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sweep_addr <= '0;
            r_sweep_left <= AW'(CELL_COUNT - 1);
            r_sweep_data <= '0;
        end else if (i_cmd.accept && is_clear) begin
            r_sweep_addr <= '0;
            r_sweep_left <= AW'(CELL_COUNT - 1);
            r_sweep_data <= {i_color, SPACE_CODE};
        end else if (i_cmd.accept && scroll) begin
            r_sweep_addr <= r_base;
            r_sweep_left <= AW'(COLUMNS - 1);
            r_sweep_data <= {r_color, SPACE_CODE};
        end else if (i_cmd.sweep_wr) begin
            r_sweep_addr <= r_sweep_addr + AW'(1);
            r_sweep_left <= r_sweep_left - AW'(1);
        end
    end

    assign mem_we = i_cmd.sweep_wr || (i_cmd.accept && is_put && !is_nl);
    assign mem_wa = i_cmd.sweep_wr ? r_sweep_addr : put_addr;
    assign mem_wd = i_cmd.sweep_wr ? r_sweep_data : {r_color, i_char_code};

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_wa] <= mem_wd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept && is_read) begin
            r_rd_data <= r_mem[rd_addr];
            r_rd_oor  <= !in_range;
        end
    end

    assign can_load = !r_out_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if ((i_cmd.accept && !is_read) || i_cmd.load_read) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept && !is_read) begin
            r_out_value  <= '0;
            r_out_col    <= 7'(n_col);
            r_out_row    <= 5'(n_row);
            r_out_scroll <= scroll;
        end else if (i_cmd.load_read) begin
            r_out_value  <= r_rd_oor ? 16'd0 : r_rd_data;
            r_out_col    <= 7'(r_col);
            r_out_row    <= 5'(r_row);
            r_out_scroll <= 1'b0;
        end
    end

    assign o_status.can_load   = can_load;
    assign o_status.is_read    = is_read;
    assign o_status.is_clear   = is_clear;
    assign o_status.scroll     = scroll;
    assign o_status.sweep_last = (r_sweep_left == '0);

    assign o_out_valid     = r_out_valid;
    assign o_cell_value    = r_out_value;
    assign o_cursor_column = r_out_col;
    assign o_cursor_row    = r_out_row;
    assign o_did_scroll    = r_out_scroll;

endmodule

`default_nettype wire

FILE: design/tcw_ctrl.sv
// ----------------------------------------------------------------------------
// tcw_ctrl
// Sequencer for the console writer: clearing pass, item intake, read wait
// and line or screen fill.
// ----------------------------------------------------------------------------
`default_nettype none

module tcw_ctrl (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_in_valid,
    input  tcw_pkg::t_dp_status  i_status,
    output tcw_pkg::t_ctl_cmd    o_cmd,
    output logic                 o_in_stall
);
    import tcw_pkg::*;

    typedef enum logic [3:0] {
        S_INIT = 4'b0001,
        S_IDLE = 4'b0010,
        S_READ = 4'b0100,
        S_FILL = 4'b1000
    } t_state;

    t_state r_state, n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_INIT: begin
                o_cmd.sweep_wr = 1'b1;
                if (i_status.sweep_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_in_valid && i_status.can_load) begin
                    o_cmd.accept = 1'b1;
                    if (i_status.is_read) begin
                        n_state = S_READ;
                    end else if (i_status.is_clear || i_status.scroll) begin
                        n_state = S_FILL;
                    end
                end
            end
            S_READ: begin
                o_cmd.load_read = 1'b1;
                n_state         = S_IDLE;
            end
            S_FILL: begin
                o_cmd.sweep_wr = 1'b1;
                if (i_status.sweep_last) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_INIT;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_stall = !((r_state == S_IDLE) && i_status.can_load);

endmodule

`default_nettype wire

FILE: design/text_console_writer_unit.sv
// ----------------------------------------------------------------------------
// text_console_writer_unit
// Text-mode screen buffer with a write cursor, scroll, clear and cell read.
//
//   channel | direction | handshake                | payload
//   --------+-----------+--------------------------+---------------------------
//   in      | to block  | i_in_valid / o_in_stall  | req_type, char_code, color,
//           |           |                          | cell_index
//   out     | from block| o_out_valid / i_out_stall| cell_value, cursor_column,
//           |           |                          | cursor_row, did_scroll
//
// Puts without scroll and unused codes finish when taken; a read waits in
// S_READ for the registered store read. A put that scrolls then blanks the
// new bottom line and a clear all COLUMNS*ROW_COUNT cells, both through the
// single store write port. After reset a clearing pass over all cells runs
// before the first item is taken. A stalled result holds in the output
// register; the next item waits until that register is free.
// ----------------------------------------------------------------------------
`default_nettype none

module text_console_writer_unit #(
    parameter int COLUMNS   = 80,
    parameter int ROW_COUNT = 25
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_in_valid,
    output logic        o_in_stall,
    input  wire  [1:0]  i_req_type,
    input  wire  [7:0]  i_char_code,
    input  wire  [7:0]  i_color,
    input  wire  [10:0] i_cell_index,
    output logic        o_out_valid,
    input  wire         i_out_stall,
    output logic [15:0] o_cell_value,
    output logic [6:0]  o_cursor_column,
    output logic [4:0]  o_cursor_row,
    output logic        o_did_scroll
);
    import tcw_pkg::*;

    t_ctl_cmd   cmd;
    t_dp_status status;

    tcw_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_status   (status),
        .o_cmd      (cmd),
        .o_in_stall (o_in_stall)
    );

    tcw_datapath #(
        .COLUMNS   (COLUMNS),
        .ROW_COUNT (ROW_COUNT)
    ) u_datapath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_status        (status),
        .i_req_type      (i_req_type),
        .i_char_code     (i_char_code),
        .i_color         (i_color),
        .i_cell_index    (i_cell_index),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_cell_value    (o_cell_value),
        .o_cursor_column (o_cursor_column),
        .o_cursor_row    (o_cursor_row),
        .o_did_scroll    (o_did_scroll)
    );

endmodule

`default_nettype wire
